// ===== sv/nlt_pkg.sv =====
// nlt_pkg: shared types, codes and constants for the narrowband lambda trim block.
// Used by nlt_cfg_regs, nlt_trim_core, narrowband_lambda_trim and nlt_checker. No dependencies.
`timescale 1ns / 1ps

package nlt_pkg;

    localparam int LEVEL_W = 10;
    localparam int CODE_W  = 8;
    localparam int STEP_W  = 5;
    localparam int TERM_W  = 8;
    localparam int DIR_W   = 2;
    localparam int HOLD_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Stream packing, tdata in whole bytes
    localparam int S_TDATA_W = 24;   // sensor_level, requested_lambda
    localparam int S_TUSER_W = 2;    // enrich_active, enlean_active
    localparam int M_TDATA_W = 16;   // correction_term, mixture_dir

    localparam logic [TERM_W-1:0] TERM_NEUTRAL = TERM_W'(100);
    localparam logic [TERM_W-1:0] TERM_LOW     = TERM_W'(90);
    localparam logic [TERM_W-1:0] TERM_HIGH    = TERM_W'(110);
    localparam logic [TERM_W-1:0] TERM_MAX     = '1;

    // Items to hold at a band end before returning to neutral (1..15)
    localparam logic [HOLD_W-1:0] HOLD_RELOAD = HOLD_W'(10);

    typedef enum logic [DIR_W-1:0] {
        DIR_RICH     = 2'd0,
        DIR_LEAN     = 2'd1,
        DIR_INACTIVE = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CTRL_ENABLE    = 3'd0,
        CFG_RICH_THRESHOLD = 3'd1,
        CFG_LEAN_THRESHOLD = 3'd2,
        CFG_STOICH_CODE    = 3'd3,
        CFG_STEP_DOWN      = 3'd4,
        CFG_STEP_UP        = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                  ctrl_enable;
        logic [LEVEL_W-1:0]    rich_threshold;
        logic [LEVEL_W-1:0]    lean_threshold;
        logic [CODE_W-1:0]     stoich_code;
        logic [STEP_W-1:0]     step_down;
        logic [STEP_W-1:0]     step_up;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] sensor_level;
        logic [CODE_W-1:0]  requested_lambda;
        logic               enrich_active;
        logic               enlean_active;
    } item_t;

    typedef struct packed {
        logic [TERM_W-1:0] correction_term;
        dir_t              mixture_dir;
    } result_t;

endpackage

// ===== sv/nlt_cfg_regs.sv =====
// nlt_cfg_regs: configuration register file written through the cfg channel.
// Depends on nlt_pkg.
`timescale 1ns / 1ps

module nlt_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [nlt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [nlt_pkg::CFG_DATA_W-1:0] wr_data,
    output nlt_pkg::cfg_t                  cfg
);

    nlt_pkg::cfg_t cfg_reg;

    // Register writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ctrl_enable    <= 1'b0;
            cfg_reg.rich_threshold <= nlt_pkg::LEVEL_W'(600);
            cfg_reg.lean_threshold <= nlt_pkg::LEVEL_W'(300);
            cfg_reg.stoich_code    <= nlt_pkg::CODE_W'(100);
            cfg_reg.step_down      <= nlt_pkg::STEP_W'(1);
            cfg_reg.step_up        <= nlt_pkg::STEP_W'(1);
        end else if (wr_en) begin
            unique case (nlt_pkg::cfg_idx_t'(wr_index))
                nlt_pkg::CFG_CTRL_ENABLE:    cfg_reg.ctrl_enable    <= wr_data[0];
                nlt_pkg::CFG_RICH_THRESHOLD: cfg_reg.rich_threshold <= wr_data;
                nlt_pkg::CFG_LEAN_THRESHOLD: cfg_reg.lean_threshold <= wr_data;
                nlt_pkg::CFG_STOICH_CODE:
                    cfg_reg.stoich_code <= wr_data[nlt_pkg::CODE_W-1:0];
                nlt_pkg::CFG_STEP_DOWN:
                    cfg_reg.step_down <= wr_data[nlt_pkg::STEP_W-1:0];
                nlt_pkg::CFG_STEP_UP:
                    cfg_reg.step_up <= wr_data[nlt_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/nlt_trim_core.sv =====
// nlt_trim_core: trim state registers and the single-pass update for one item.
// Depends on nlt_pkg.
`timescale 1ns / 1ps

module nlt_trim_core #(
    parameter logic [nlt_pkg::HOLD_W-1:0] HOLD_RELOAD = nlt_pkg::HOLD_RELOAD
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  nlt_pkg::cfg_t    cfg,
    input  nlt_pkg::item_t   item,
    input  logic             advance,
    output nlt_pkg::result_t result
);

    logic [nlt_pkg::TERM_W-1:0] term_reg,  term_next;
    nlt_pkg::dir_t              dir_reg,   dir_next;
    nlt_pkg::dir_t              last_dir_reg, last_dir_next;
    logic [nlt_pkg::HOLD_W-1:0] rich_cnt_reg, rich_cnt_next;
    logic [nlt_pkg::HOLD_W-1:0] lean_cnt_reg, lean_cnt_next;

    logic                       active;
    nlt_pkg::dir_t              dir_class;
    logic [nlt_pkg::TERM_W-1:0] base;
    logic [nlt_pkg::TERM_W:0]   sum;

    // Classify the sample; rich test wins when both thresholds are met
    always_comb begin
        if (item.sensor_level > cfg.rich_threshold) begin
            dir_class = nlt_pkg::DIR_RICH;
        end else if (item.sensor_level < cfg.lean_threshold) begin
            dir_class = nlt_pkg::DIR_LEAN;
        end else begin
            dir_class = nlt_pkg::DIR_INACTIVE;
        end
    end

    assign active = cfg.ctrl_enable && !item.enrich_active && !item.enlean_active;
    // A change of direction restarts from neutral
    assign base = (dir_class != last_dir_reg) ? nlt_pkg::TERM_NEUTRAL : term_reg;
    assign sum  = {1'b0, base} + {{(nlt_pkg::TERM_W+1-nlt_pkg::STEP_W){1'b0}}, cfg.step_up};

    // Next state for the item now leaving the input register
    always_comb begin
        term_next     = term_reg;
        dir_next      = dir_reg;
        last_dir_next = last_dir_reg;
        rich_cnt_next = rich_cnt_reg;
        lean_cnt_next = lean_cnt_reg;
        if (active) begin
            dir_next = dir_class;
            if (item.requested_lambda != cfg.stoich_code ||
                dir_class == nlt_pkg::DIR_INACTIVE) begin
                term_next = nlt_pkg::TERM_NEUTRAL;
            end else begin
                last_dir_next = dir_class;
                term_next     = base;
                if (dir_class == nlt_pkg::DIR_RICH) begin
                    if (base <= nlt_pkg::TERM_LOW) begin
                        if (rich_cnt_reg == '0) begin
                            rich_cnt_next = HOLD_RELOAD;
                            term_next     = nlt_pkg::TERM_NEUTRAL;
                        end else begin
                            rich_cnt_next = rich_cnt_reg - 1'b1;
                        end
                    end else if (base >= nlt_pkg::TERM_W'(cfg.step_down)) begin
                        term_next = base - nlt_pkg::TERM_W'(cfg.step_down);
                    end else begin
                        term_next = '0;
                    end
                end else begin
                    if (base >= nlt_pkg::TERM_HIGH) begin
                        if (lean_cnt_reg == '0) begin
                            lean_cnt_next = HOLD_RELOAD;
                            term_next     = nlt_pkg::TERM_NEUTRAL;
                        end else begin
                            lean_cnt_next = lean_cnt_reg - 1'b1;
                        end
                    end else if (sum[nlt_pkg::TERM_W]) begin
                        term_next = nlt_pkg::TERM_MAX;
                    end else begin
                        term_next = sum[nlt_pkg::TERM_W-1:0];
                    end
                end
            end
        end
    end

    // State update on each transfer into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg     <= nlt_pkg::TERM_NEUTRAL;
            dir_reg      <= nlt_pkg::DIR_INACTIVE;
            last_dir_reg <= nlt_pkg::DIR_RICH;
            rich_cnt_reg <= '0;
            lean_cnt_reg <= '0;
        end else if (advance) begin
            term_reg     <= term_next;
            dir_reg      <= dir_next;
            last_dir_reg <= last_dir_next;
            rich_cnt_reg <= rich_cnt_next;
            lean_cnt_reg <= lean_cnt_next;
        end
    end

    assign result.correction_term = term_next;
    assign result.mixture_dir     = dir_next;

endmodule

// ===== sv/narrowband_lambda_trim.sv =====
// narrowband_lambda_trim: top level, input register, result register and handshakes.
// Depends on nlt_pkg, nlt_cfg_regs and nlt_trim_core.
//
// Closed-loop fuel trim from a narrow-band oxygen sensor. Each transfer on the
// s_axis channel carries one sensor sample and a requested lambda code in tdata
// and the two suspend flags in tuser. Each one yields exactly one result on
// m_axis: the correction term (100 = neutral) and the mixture class.
// m_axis_tvalid is registered: each item passes through the input register and then
// the result register. The trim update is compares and one add or subtract between
// those registers, so one item per clock is sustained while m_axis_tready stays high.
// Settings are written on the cfg channel (always ready); the user must write them
// only while the block is idle, and the block itself does not enforce it.
// Reset (aresetn low, synchronous) empties both registers, puts the term at
// 100 with the class inactive and loads the default settings.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more item; s_axis_tready drops only once
// both registers are full.
`timescale 1ns / 1ps

module narrowband_lambda_trim #(
    parameter logic [nlt_pkg::HOLD_W-1:0] HOLD_RELOAD = nlt_pkg::HOLD_RELOAD
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [nlt_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] sensor_level, [17:10] requested_lambda
    input  logic [nlt_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // [0] enrich_active, [1] enlean_active
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nlt_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [7:0] correction_term, [9:8] mixture_dir
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nlt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    nlt_pkg::cfg_t    cfg;
    nlt_pkg::item_t   item_reg;
    logic             in_valid_reg;
    nlt_pkg::result_t result, out_reg;
    logic             out_valid_reg;
    logic             advance;

    assign cfg_ready = 1'b1;

    nlt_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    // Item moves on when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg.sensor_level     <= s_axis_tdata[nlt_pkg::LEVEL_W-1:0];
            item_reg.requested_lambda <=
                s_axis_tdata[nlt_pkg::LEVEL_W +: nlt_pkg::CODE_W];
            item_reg.enrich_active    <= s_axis_tuser[0];
            item_reg.enlean_active    <= s_axis_tuser[1];
        end
    end

    nlt_trim_core #(
        .HOLD_RELOAD (HOLD_RELOAD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(nlt_pkg::M_TDATA_W-nlt_pkg::TERM_W-nlt_pkg::DIR_W){1'b0}},
                            out_reg.mixture_dir, out_reg.correction_term};

endmodule

// ===== sv/nlt_checker.sv =====
// nlt_checker: port-level assertions for narrowband_lambda_trim, with its bind.
// Depends on nlt_pkg and the top level's ports.
`timescale 1ns / 1ps

module nlt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [nlt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          cfg_ready
);

    // A stalled result keeps its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input backpressure only when both stages are full and the output is stalled
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // The inactive class always comes with a neutral term
    a_inactive_neutral: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[9:8] == nlt_pkg::DIR_INACTIVE
        |-> m_axis_tdata[7:0] == nlt_pkg::TERM_NEUTRAL)
        else $error("inactive class with non-neutral term");

    // Class code never holds the unused value and padding stays zero
    a_dir_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3 && m_axis_tdata[15:10] == '0)
        else $error("illegal class code or padding");

    // With the result register empty, an offered input item is taken and cfg_ready is high
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && s_axis_tvalid |-> s_axis_tready && cfg_ready)
        else $error("idle pipeline refused input");

endmodule

bind narrowband_lambda_trim nlt_checker u_nlt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);
